>>> rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Types and constants shared by the interval stabbing counter.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int MAX_INTERVALS = 256;
  localparam int FILL_W        = $clog2(MAX_INTERVALS + 1);
  localparam int COORD_W       = 32;
  localparam int COUNT_W       = 9;

  // one stored interval; keys are coordinates with the sign bit inverted
  typedef struct packed {
    logic               vld;
    logic [COORD_W-1:0] lkey;
    logic [COORD_W-1:0] rkey;
  } isc_entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } isc_cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_PASS
  } isc_state_t;

  function automatic logic [COORD_W-1:0] to_key(input logic [COORD_W-1:0] coord);
    return {~coord[COORD_W-1], coord[COORD_W-2:0]};
  endfunction

endpackage

>>> rtl/isc_cell.sv
// ----------------------------------------------------------------------------
// isc_cell
// One slot of the sorted chain: insert in place, shift right, or pop left.
// ----------------------------------------------------------------------------
module isc_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  isc_pkg::isc_cell_ctl_t ctl,
  input  isc_pkg::isc_entry_t    new_ent,
  input  isc_pkg::isc_entry_t    prev_ent,
  input  logic                   prev_before,
  input  isc_pkg::isc_entry_t    next_ent,
  output logic                   before_o,
  output isc_pkg::isc_entry_t    ent_o
);

  isc_pkg::isc_entry_t ent_r;
  isc_pkg::isc_entry_t ent_nxt;

  // new interval ranks strictly ahead of this slot (an empty slot ranks last)
  assign before_o = !ent_r.vld || (new_ent.rkey < ent_r.rkey) ||
                    ((new_ent.rkey == ent_r.rkey) && (new_ent.lkey > ent_r.lkey));

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.pop) begin
      ent_nxt = next_ent;
    end else if (ctl.ins) begin
      if (prev_before) begin
        ent_nxt = prev_ent;
      end else if (before_o) begin
        ent_nxt = new_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r.lkey <= ent_nxt.lkey;
    ent_r.rkey <= ent_nxt.rkey;
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
  end

  assign ent_o = ent_r;

endmodule

>>> rtl/isc_greedy.sv
// ----------------------------------------------------------------------------
// isc_greedy
// Point counter fed by the head of the chain, one interval per cycle while step is high.
// ----------------------------------------------------------------------------
module isc_greedy (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               clr,
  input  logic                               step,
  input  isc_pkg::isc_entry_t                head,
  output logic [isc_pkg::COUNT_W-1:0]        count
);

  logic [isc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [isc_pkg::COORD_W-1:0] bound_r, bound_nxt;
  logic                        have_r, have_nxt;
  logic                        pick;

  // a new point is needed unless the interval starts below the current point
  assign pick = !have_r || !(head.lkey < bound_r);

  always_comb begin
    count_nxt = count_r;
    bound_nxt = bound_r;
    have_nxt  = have_r;
    if (clr) begin
      count_nxt = '0;
      have_nxt  = 1'b0;
    end else if (step && head.vld && pick) begin
      count_nxt = count_r + isc_pkg::COUNT_W'(1);
      bound_nxt = head.rkey;
      have_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    bound_r <= bound_nxt;
    if (!rst_n) begin
      count_r <= '0;
      have_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      have_r  <= have_nxt;
    end
  end

  assign count = count_r;

endmodule

>>> rtl/interval_stabbing_count.sv
// ----------------------------------------------------------------------------
// interval_stabbing_count
// Greedy minimum point cover over a set of signed intervals.
// ----------------------------------------------------------------------------
// Usage:
//   Present one interval on in_left_end / in_right_end with in_last_interval
//   and raise start. The request is taken on a rising edge where start is
//   high and busy is low. Intervals are kept in a chain of cells sorted by
//   right end (ties: larger left end first); each request is placed on the
//   edge that takes it, so while loading a request can be taken every cycle.
//   The request marked last closes the set: busy rises and the chain is
//   emptied through its head, one cell per cycle, into the point counter.
//   With N stored intervals, the head passes all N cells to the counter and
//   then out_valid pulses for one cycle, carrying out_point_count and
//   out_overflow. Busy holds from the edge that took the last request until
//   the result is shown, so no request of the next set is taken while the
//   chain is being drained.
//   Intervals arriving with the chain full are dropped and out_overflow of
//   the set is raised. The receiver cannot stall: the result is shown once.
//   Synchronous reset empties the chain, clears fill level and pending overflow.
// ----------------------------------------------------------------------------
module interval_stabbing_count (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [isc_pkg::COORD_W-1:0] in_left_end,
  input  logic signed [isc_pkg::COORD_W-1:0] in_right_end,
  input  logic                               in_last_interval,
  output logic                               out_valid,
  output logic [isc_pkg::COUNT_W-1:0]        out_point_count,
  output logic                               out_overflow
);

  localparam int N = isc_pkg::MAX_INTERVALS;

  isc_pkg::isc_state_t    state_r, state_nxt;
  logic [isc_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [isc_pkg::COUNT_W-1:0] count_out_r, count_out_nxt;
  logic                   ovf_out_r, ovf_out_nxt;

  logic                   accept;
  logic                   room;
  logic                   greedy_clr;
  logic [isc_pkg::COUNT_W-1:0] greedy_count;
  isc_pkg::isc_cell_ctl_t ctl;
  isc_pkg::isc_entry_t    new_ent;
  isc_pkg::isc_entry_t    ent [N];
  logic                   ahead [N];

  assign busy   = (state_r == isc_pkg::ST_PASS);
  assign accept = start && !busy;
  assign room   = fill_r < isc_pkg::FILL_W'(N);

  // convert the request into sortable keys
  assign new_ent.vld  = 1'b1;
  assign new_ent.lkey = isc_pkg::to_key(in_left_end);
  assign new_ent.rkey = isc_pkg::to_key(in_right_end);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    count_out_nxt = count_out_r;
    ovf_out_nxt   = ovf_out_r;
    ctl.ins       = 1'b0;
    ctl.pop       = 1'b0;
    greedy_clr    = 1'b0;
    unique case (state_r)
      isc_pkg::ST_LOAD: begin
        if (accept) begin
          // place the interval, or drop it when the chain is full
          if (room) begin
            ctl.ins  = 1'b1;
            fill_nxt = fill_r + isc_pkg::FILL_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_interval) begin
            state_nxt = isc_pkg::ST_PASS;
          end
        end
      end
      isc_pkg::ST_PASS: begin
        if (fill_r != '0) begin
          // advance the chain by one cell into the counter
          ctl.pop  = 1'b1;
          fill_nxt = fill_r - isc_pkg::FILL_W'(1);
        end else begin
          // drained: emit the result and clear for the next set
          out_valid_nxt = 1'b1;
          count_out_nxt = greedy_count;
          ovf_out_nxt   = ovf_r;
          ovf_nxt       = 1'b0;
          greedy_clr    = 1'b1;
          state_nxt     = isc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = isc_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    count_out_r <= count_out_nxt;
    ovf_out_r   <= ovf_out_nxt;
    if (!rst_n) begin
      state_r     <= isc_pkg::ST_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sorted chain: head at index 0, empty cells gather at the tail
  for (genvar i = 0; i < N; i++) begin : g_cell
    isc_pkg::isc_entry_t prev_e;
    isc_pkg::isc_entry_t next_e;
    logic                prev_b;
    if (i == 0) begin : g_head
      assign prev_e = new_ent;
      assign prev_b = 1'b0;
    end else begin : g_body
      assign prev_e = ent[i-1];
      assign prev_b = ahead[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = ent[i+1];
    end
    isc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_ent     (new_ent),
      .prev_ent    (prev_e),
      .prev_before (prev_b),
      .next_ent    (next_e),
      .before_o    (ahead[i]),
      .ent_o       (ent[i])
    );
  end

  isc_greedy u_greedy (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (greedy_clr),
    .step  (ctl.pop),
    .head  (ent[0]),
    .count (greedy_count)
  );

  assign out_valid       = out_valid_r;
  assign out_point_count = count_out_r;
  assign out_overflow    = ovf_out_r;

  // fill level never exceeds the chain length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= isc_pkg::FILL_W'(N))
    else $error("fill level beyond capacity");

  // while draining, the head cell holds an interval
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && fill_r != '0) |-> ent[0].vld)
    else $error("drain reached an empty head cell");

  // a result leaves the chain empty and the block ready
  a_result_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (fill_r == '0 && !busy && !ent[0].vld))
    else $error("result shown with chain not empty");

  // one strobe per set
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule
